// ===== rtl/sbfpd_pkg.sv =====
// Shared types and constants for the six-byte frame port deframer.
`timescale 1ns / 1ps

package sbfpd_pkg;

    localparam int unsigned VALUE_W     = 26;
    localparam int unsigned CHAN_W      = 9;
    localparam int unsigned STORE_DEPTH = 512;
    localparam int unsigned STORE_AW    = $clog2(STORE_DEPTH);

    localparam logic [VALUE_W-1:0] FULL_MASK = {VALUE_W{1'b1}};

    // Byte position of the last byte of a frame (positions count from 0).
    localparam logic [2:0] LAST_POS = 3'd5;

    // I/O types that own a port store
    localparam logic [2:0] IO_PIO = 3'd0;
    localparam logic [2:0] IO_CIO = 3'd1;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_SRC_MISMATCH  = 3'd1,
        ST_TYPE_MISMATCH = 3'd2,
        ST_CHAN_MISMATCH = 3'd3,
        ST_STRAY         = 3'd4,
        ST_RESTART       = 3'd5
    } status_t;

endpackage

// ===== rtl/six_byte_frame_port_deframer.sv =====
// Six-byte frame deframer with masked merge into two port stores.
`timescale 1ns / 1ps
// A result word is loaded into stage 1 at the edge that accepts the byte causing it and
//   then into the output register when that is empty or being taken; it is held until taken.
// Throughput: one byte per cycle while in_ready is high; a completed data frame reads its store
//   word at the accept edge and writes the merged word back as stage 1 moves on.
// Reset: asynchronous, active low; afterwards both 512-word stores are swept to zero,
//   one word per cycle, with in_ready held low.

module six_byte_frame_port_deframer
(
    input  logic         clk,
    input  logic         rst_n,

    input  logic         in_valid,
    output logic         in_ready,
    input  logic [7:0]   rx_byte,

    output logic         out_valid,
    input  logic         out_ready,
    output logic [2:0]   status,
    output logic [2:0]   source_id,
    output logic [2:0]   io_type,
    output logic [8:0]   port_channel,
    output logic [25:0]  payload,
    output logic [25:0]  applied_mask,
    output logic [25:0]  merged_word
);

    localparam int unsigned VW = sbfpd_pkg::VALUE_W;
    localparam int unsigned CW = sbfpd_pkg::CHAN_W;
    localparam int unsigned AW = sbfpd_pkg::STORE_AW;

    // ------------------------------------------------------------------
    // Frame assembly state
    // ------------------------------------------------------------------
    logic [2:0]     pos_reg,         pos_next;
    logic           frame_mask_reg,  frame_mask_next;
    logic [2:0]     frame_type_reg,  frame_type_next;
    logic [2:0]     frame_src_reg,   frame_src_next;
    logic [CW-1:0]  frame_chan_reg,  frame_chan_next;
    logic [VW-1:0]  frame_value_reg, frame_value_next;

    // Mask frame held for the next data frame
    logic           held_valid_reg,  held_valid_next;
    logic [2:0]     held_src_reg,    held_src_next;
    logic [2:0]     held_type_reg,   held_type_next;
    logic [CW-1:0]  held_chan_reg,   held_chan_next;
    logic [VW-1:0]  held_bits_reg,   held_bits_next;

    // Store clearing sweep after reset
    logic           clearing_reg;
    logic [AW-1:0]  clr_idx_reg;

    // Result stage 1: holds the frame fields while the store read data is registered
    logic                s1_valid_reg;
    sbfpd_pkg::status_t  s1_status_reg;
    logic [2:0]          s1_src_reg;
    logic [2:0]          s1_type_reg;
    logic [CW-1:0]       s1_chan_reg;
    logic [VW-1:0]       s1_value_reg;
    logic [VW-1:0]       s1_mask_reg;
    logic                s1_merge_reg;

    // Stage 1 load values
    logic                s1_load;
    sbfpd_pkg::status_t  s1_status_d;
    logic [2:0]          s1_src_d;
    logic [2:0]          s1_type_d;
    logic [CW-1:0]       s1_chan_d;
    logic [VW-1:0]       s1_value_d;
    logic [VW-1:0]       s1_mask_d;
    logic                s1_merge_d;

    // Output register
    logic                out_valid_reg;
    sbfpd_pkg::status_t  out_status_reg;
    logic [2:0]          out_src_reg;
    logic [2:0]          out_type_reg;
    logic [CW-1:0]       out_chan_reg;
    logic [VW-1:0]       out_value_reg;
    logic [VW-1:0]       out_mask_reg;
    logic [VW-1:0]       out_merged_reg;

    // Port stores
    logic [VW-1:0]  pri_mem [sbfpd_pkg::STORE_DEPTH];
    logic [VW-1:0]  cmd_mem [sbfpd_pkg::STORE_DEPTH];
    logic [VW-1:0]  pri_rdata_reg;
    logic [VW-1:0]  cmd_rdata_reg;

    logic           in_fire;
    logic           marker;
    logic           pos_idle;
    logic [VW-1:0]  value_full;
    logic           rd_en;
    logic           s1_adv;
    logic           s1_commit;
    logic [VW-1:0]  old_word;
    logic [VW-1:0]  merged;
    logic           pri_we;
    logic           cmd_we;
    logic [AW-1:0]  wr_addr;
    logic [VW-1:0]  wr_data;

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    // Stage 1 moves on whenever the output register is empty or being taken;
    // take a new byte whenever stage 1 is free or moving on and no clearing sweep runs.
    assign s1_adv    = !out_valid_reg || out_ready;
    assign s1_commit = s1_valid_reg && s1_adv;
    assign in_ready  = !clearing_reg && (!s1_valid_reg || s1_adv);
    assign in_fire   = in_valid && in_ready;

    assign marker     = rx_byte[7];
    // Positions above the last one never occur, but treat them as no frame open.
    assign pos_idle   = (pos_reg == 3'd0) || (pos_reg > sbfpd_pkg::LAST_POS);
    assign value_full = {frame_value_reg[VW-1:7], rx_byte[6:0]};

    // ------------------------------------------------------------------
    // Byte decode: frame assembly, held mask and stage 1 load
    // ------------------------------------------------------------------
    always_comb
    begin
        pos_next         = pos_reg;
        frame_mask_next  = frame_mask_reg;
        frame_type_next  = frame_type_reg;
        frame_src_next   = frame_src_reg;
        frame_chan_next  = frame_chan_reg;
        frame_value_next = frame_value_reg;
        held_valid_next  = held_valid_reg;
        held_src_next    = held_src_reg;
        held_type_next   = held_type_reg;
        held_chan_next   = held_chan_reg;
        held_bits_next   = held_bits_reg;

        s1_load     = 1'b0;
        s1_status_d = sbfpd_pkg::ST_OK;
        s1_src_d    = 3'd0;
        s1_type_d   = 3'd0;
        s1_chan_d   = '0;
        s1_value_d  = '0;
        s1_mask_d   = '0;
        s1_merge_d  = 1'b0;
        rd_en       = 1'b0;

        if (in_fire)
        begin
            if (pos_idle && !marker)
            begin
                // Drop a stray byte outside any frame
                pos_next    = 3'd0;
                s1_load     = 1'b1;
                s1_status_d = sbfpd_pkg::ST_STRAY;
            end
            else if (marker)
            begin
                // Open a new frame; abandon any partial one
                frame_mask_next  = rx_byte[6];
                frame_type_next  = rx_byte[5:3];
                frame_src_next   = rx_byte[2:0];
                frame_chan_next  = '0;
                frame_value_next = '0;
                pos_next         = 3'd1;
                if (!pos_idle)
                begin
                    s1_load     = 1'b1;
                    s1_status_d = sbfpd_pkg::ST_RESTART;
                end
            end
            else
            begin
                unique case (pos_reg)
                    3'd1:
                    begin
                        frame_chan_next = {2'b00, rx_byte[6:0]};
                        pos_next        = 3'd2;
                    end
                    3'd2:
                    begin
                        frame_chan_next  = {rx_byte[6:5], frame_chan_reg[6:0]};
                        frame_value_next = {rx_byte[4:0], 21'd0};
                        pos_next         = 3'd3;
                    end
                    3'd3:
                    begin
                        frame_value_next = {frame_value_reg[VW-1:21], rx_byte[6:0], 14'd0};
                        pos_next         = 3'd4;
                    end
                    3'd4:
                    begin
                        frame_value_next = {frame_value_reg[VW-1:14], rx_byte[6:0], 7'd0};
                        pos_next         = sbfpd_pkg::LAST_POS;
                    end
                    default:
                    begin
                        // Last byte: frame complete
                        frame_value_next = value_full;
                        pos_next         = 3'd0;
                        s1_load          = 1'b1;
                        s1_src_d         = frame_src_reg;
                        s1_type_d        = frame_type_reg;
                        s1_chan_d        = frame_chan_reg;
                        s1_value_d       = value_full;
                        s1_mask_d        = sbfpd_pkg::FULL_MASK;
                        if (frame_mask_reg)
                        begin
                            held_valid_next = 1'b1;
                            held_src_next   = frame_src_reg;
                            held_type_next  = frame_type_reg;
                            held_chan_next  = frame_chan_reg;
                            held_bits_next  = value_full;
                        end
                        else
                        begin
                            if (held_valid_reg)
                            begin
                                priority if (held_src_reg != frame_src_reg)
                                    s1_status_d = sbfpd_pkg::ST_SRC_MISMATCH;
                                else if (held_type_reg != frame_type_reg)
                                    s1_status_d = sbfpd_pkg::ST_TYPE_MISMATCH;
                                else if (held_chan_reg != frame_chan_reg)
                                    s1_status_d = sbfpd_pkg::ST_CHAN_MISMATCH;
                                else
                                    s1_mask_d = held_bits_reg;
                            end
                            held_valid_next = 1'b0;
                            s1_merge_d = (frame_type_reg == sbfpd_pkg::IO_PIO) ||
                                         (frame_type_reg == sbfpd_pkg::IO_CIO);
                            rd_en      = s1_merge_d;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= 3'd0;
            frame_mask_reg  <= 1'b0;
            frame_type_reg  <= 3'd0;
            frame_src_reg   <= 3'd0;
            frame_chan_reg  <= '0;
            frame_value_reg <= '0;
            held_valid_reg  <= 1'b0;
            held_src_reg    <= 3'd0;
            held_type_reg   <= 3'd0;
            held_chan_reg   <= '0;
            held_bits_reg   <= '0;
        end
        else
        begin
            pos_reg         <= pos_next;
            frame_mask_reg  <= frame_mask_next;
            frame_type_reg  <= frame_type_next;
            frame_src_reg   <= frame_src_next;
            frame_chan_reg  <= frame_chan_next;
            frame_value_reg <= frame_value_next;
            held_valid_reg  <= held_valid_next;
            held_src_reg    <= held_src_next;
            held_type_reg   <= held_type_next;
            held_chan_reg   <= held_chan_next;
            held_bits_reg   <= held_bits_next;
        end
    end

    // ------------------------------------------------------------------
    // Clearing sweep: zero one word of each store per cycle after reset
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            clr_idx_reg <= clr_idx_reg + AW'(1);
            if (clr_idx_reg == AW'(sbfpd_pkg::STORE_DEPTH - 1))
                clearing_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_load)
            s1_valid_reg <= 1'b1;
        else if (s1_adv)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_status_reg <= s1_status_d;
            s1_src_reg    <= s1_src_d;
            s1_type_reg   <= s1_type_d;
            s1_chan_reg   <= s1_chan_d;
            s1_value_reg  <= s1_value_d;
            s1_mask_reg   <= s1_mask_d;
            s1_merge_reg  <= s1_merge_d;
        end
    end

    // ------------------------------------------------------------------
    // Read-modify-write. The read is issued with the last byte of a frame
    // and the merged word is written back as stage 1 moves on. A later
    // frame's read comes at least five accepted bytes after that write,
    // so the same word is never read and written in one cycle.
    // ------------------------------------------------------------------
    assign old_word = (s1_type_reg == sbfpd_pkg::IO_CIO) ? cmd_rdata_reg : pri_rdata_reg;
    assign merged   = s1_merge_reg
                    ? ((old_word & ~s1_mask_reg) | (s1_value_reg & s1_mask_reg))
                    : '0;

    assign pri_we  = clearing_reg ||
                     (s1_commit && s1_merge_reg && (s1_type_reg == sbfpd_pkg::IO_PIO));
    assign cmd_we  = clearing_reg ||
                     (s1_commit && s1_merge_reg && (s1_type_reg == sbfpd_pkg::IO_CIO));
    assign wr_addr = clearing_reg ? clr_idx_reg : s1_chan_reg[AW-1:0];
    assign wr_data = clearing_reg ? '0 : merged;

    always_ff @(posedge clk)
    begin
        if (pri_we)
            pri_mem[wr_addr] <= wr_data;
        if (rd_en)
            pri_rdata_reg <= pri_mem[frame_chan_reg[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd_we)
            cmd_mem[wr_addr] <= wr_data;
        if (rd_en)
            cmd_rdata_reg <= cmd_mem[frame_chan_reg[AW-1:0]];
    end

    // ------------------------------------------------------------------
    // Output register: hold until taken, advance from stage 1
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_adv)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_commit)
        begin
            out_status_reg <= s1_status_reg;
            out_src_reg    <= s1_src_reg;
            out_type_reg   <= s1_type_reg;
            out_chan_reg   <= s1_chan_reg;
            out_value_reg  <= s1_value_reg;
            out_mask_reg   <= s1_mask_reg;
            out_merged_reg <= merged;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign source_id    = out_src_reg;
    assign io_type      = out_type_reg;
    assign port_channel = out_chan_reg;
    assign payload      = out_value_reg;
    assign applied_mask = out_mask_reg;
    assign merged_word  = out_merged_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_rmw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && s1_commit && s1_merge_reg) |-> (frame_chan_reg != s1_chan_reg))
        else $error("store read and write-back hit the same word in one cycle");

    a_no_merge_other_type: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_type_reg != sbfpd_pkg::IO_PIO) &&
         (out_type_reg != sbfpd_pkg::IO_CIO)) |-> (out_merged_reg == '0))
        else $error("merged word set for a type without a port store");

    a_fault_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ((out_status_reg == sbfpd_pkg::ST_STRAY) ||
                           (out_status_reg == sbfpd_pkg::ST_RESTART)))
        |-> ((out_value_reg == '0) && (out_mask_reg == '0) && (out_chan_reg == '0)))
        else $error("fault result carries frame fields");

    a_mismatch_full_mask: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ((out_status_reg == sbfpd_pkg::ST_SRC_MISMATCH) ||
                           (out_status_reg == sbfpd_pkg::ST_TYPE_MISMATCH) ||
                           (out_status_reg == sbfpd_pkg::ST_CHAN_MISMATCH)))
        |-> (out_mask_reg == sbfpd_pkg::FULL_MASK))
        else $error("mask mismatch did not fall back to the full mask");

    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !s1_load)
        else $error("result produced during the store clearing sweep");

endmodule
